// File: sv/assert_macros.svh
// Assertion macros for the checker file qep_checker.
// No dependencies; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define QEP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define QEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/qep_pkg.sv
// Shared types and constants for the quadrature encoder position tracker.
// No dependencies.
`timescale 1ns / 1ps

package qep_pkg;

	localparam int POSITION_WIDTH_DEF = 8;
	localparam int CFG_DATA_W         = 8;
	localparam int CFG_INDEX_W        = 2;

	localparam int POS_MIN_RST = 2;
	localparam int POS_MAX_RST = 4;
	localparam int POS_CNT_RST = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POSITION_MIN = 2'd0,
		REG_POSITION_MAX = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2,
		PH_BOTH  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   left_pend;
		logic   right_pend;
	} qep_fsm_t;

endpackage

// File: sv/qep_step.sv
// Next-state and position-step logic for one phase sample.
// Depends on qep_pkg.
`timescale 1ns / 1ps

module qep_step #(
	parameter int POS_W = qep_pkg::POSITION_WIDTH_DEF
) (
	input  qep_pkg::qep_fsm_t cur,
	input  logic              phase_a,
	input  logic              phase_b,
	input  logic [POS_W-1:0]  count,
	input  logic [POS_W-1:0]  pos_min,
	input  logic [POS_W-1:0]  pos_max,
	output qep_pkg::qep_fsm_t nxt,
	output logic [POS_W-1:0]  nxt_count
);

	logic [POS_W-1:0] inc_val;
	logic [POS_W-1:0] dec_val;
	logic             lvl_00;
	logic             lvl_01;
	logic             lvl_10;
	logic             lvl_11;

	assign inc_val = (count >= pos_max) ? pos_min : count + 1'b1;
	assign dec_val = (count <= pos_min) ? pos_max : count - 1'b1;

	assign lvl_00 = !phase_a && !phase_b;
	assign lvl_01 = !phase_a &&  phase_b;
	assign lvl_10 =  phase_a && !phase_b;
	assign lvl_11 =  phase_a &&  phase_b;

	always_comb begin
		nxt       = cur;
		nxt_count = count;
		case (cur.phase)
			qep_pkg::PH_IDLE: begin
				if (lvl_01) begin
					nxt.phase = qep_pkg::PH_LEFT;
				end else if (lvl_10) begin
					nxt.phase = qep_pkg::PH_RIGHT;
				end
			end
			qep_pkg::PH_LEFT: begin
				if (lvl_00) begin
					nxt.left_pend = 1'b1;
					nxt.phase     = qep_pkg::PH_BOTH;
				end else if (lvl_11) begin
					nxt.phase = qep_pkg::PH_IDLE;
				end
			end
			qep_pkg::PH_RIGHT: begin
				if (lvl_00) begin
					nxt.right_pend = 1'b1;
					nxt.phase      = qep_pkg::PH_BOTH;
				end else if (lvl_11) begin
					nxt.phase = qep_pkg::PH_IDLE;
				end
			end
			qep_pkg::PH_BOTH: begin
				// completed detent first, then re-entry to a side state
				if (lvl_10) begin
					if (cur.left_pend) begin
						nxt.left_pend = 1'b0;
						nxt_count     = inc_val;
						nxt.phase     = qep_pkg::PH_IDLE;
					end
					if (cur.right_pend) begin
						nxt.right_pend = 1'b0;
						nxt.phase      = qep_pkg::PH_RIGHT;
					end
				end else if (lvl_01) begin
					if (cur.right_pend) begin
						nxt.right_pend = 1'b0;
						nxt_count      = dec_val;
						nxt.phase      = qep_pkg::PH_IDLE;
					end
					if (cur.left_pend) begin
						nxt.left_pend = 1'b0;
						nxt.phase     = qep_pkg::PH_LEFT;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: sv/quadrature_encoder_position.sv
// Quadrature encoder position tracker, top level. Depends on qep_pkg and qep_step.
// An accepted input passes through the input register, then the result register.
// Throughput: one sample per cycle unless out_stall holds the result, which backs up into in_stall.
// Reset (arst_n low, asynchronous): idle phase, no pending marks, count 2, range 2..4; position is not reset.
`timescale 1ns / 1ps

module quadrature_encoder_position #(
	parameter int POSITION_WIDTH = qep_pkg::POSITION_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            phase_a,
	input  logic                            phase_b,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [POSITION_WIDTH-1:0]       position,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qep_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [qep_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int EXT_W = POSITION_WIDTH + qep_pkg::CFG_DATA_W;

	logic                      valid_s1;
	logic                      a_s1;
	logic                      b_s1;
	logic                      valid_s2;
	logic [POSITION_WIDTH-1:0] pos_s2;

	qep_pkg::qep_fsm_t         fsm_q;
	qep_pkg::qep_fsm_t         fsm_nxt;
	logic [POSITION_WIDTH-1:0] count_q;
	logic [POSITION_WIDTH-1:0] count_nxt;
	logic [POSITION_WIDTH-1:0] pos_min_q;
	logic [POSITION_WIDTH-1:0] pos_max_q;

	logic [EXT_W-1:0]          cfg_ext;
	logic [POSITION_WIDTH-1:0] cfg_val;
	logic                      in_xfer;
	logic                      out_load;
	logic                      adv;

	assign out_load = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;
	assign in_xfer  = in_valid && !in_stall;

	assign out_valid = valid_s2;
	assign position  = pos_s2;
	assign cfg_ready = 1'b1;

	assign cfg_ext = {{POSITION_WIDTH{1'b0}}, cfg_data};
	assign cfg_val = cfg_ext[POSITION_WIDTH-1:0];

	qep_step #(
		.POS_W (POSITION_WIDTH)
	) u_step (
		.cur       (fsm_q),
		.phase_a   (a_s1),
		.phase_b   (b_s1),
		.count     (count_q),
		.pos_min   (pos_min_q),
		.pos_max   (pos_max_q),
		.nxt       (fsm_nxt),
		.nxt_count (count_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			a_s1 <= phase_a;
			b_s1 <= phase_b;
		end
	end

	// tracker state, advanced once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= '{phase: qep_pkg::PH_IDLE, left_pend: 1'b0, right_pend: 1'b0};
			count_q <= POSITION_WIDTH'(qep_pkg::POS_CNT_RST);
		end else if (adv) begin
			fsm_q   <= fsm_nxt;
			count_q <= count_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2 <= count_nxt;
		end
	end

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q <= POSITION_WIDTH'(qep_pkg::POS_MIN_RST);
			pos_max_q <= POSITION_WIDTH'(qep_pkg::POS_MAX_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qep_pkg::REG_POSITION_MIN: pos_min_q <= cfg_val;
				qep_pkg::REG_POSITION_MAX: pos_max_q <= cfg_val;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/qep_checker.sv
// Port-level checks for quadrature_encoder_position, bound to every instance.
// Depends on assert_macros.svh and qep_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qep_checker #(
	parameter int POSITION_WIDTH = qep_pkg::POSITION_WIDTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [POSITION_WIDTH-1:0] position,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);

	`QEP_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`QEP_ASSERT(a_pos_hold, clk, arst_n, out_valid && out_stall |=> $stable(position), "stalled position changed")
	`QEP_ASSERT(a_no_bubble_stall, clk, arst_n, !out_valid |-> !in_stall, "input stalled with empty result stage")
	`QEP_ASSERT(a_result_follows, clk, arst_n, in_valid && !in_stall |=> ##1 out_valid, "transfer produced no result")
	`QEP_ASSERT_ALWAYS(a_cfg_taken, clk, cfg_valid |-> cfg_ready, "configuration transfer refused")

endmodule

bind quadrature_encoder_position qep_checker #(
	.POSITION_WIDTH (POSITION_WIDTH)
) u_qep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.position  (position),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
